/* design/fat_block_chain_manager_macros.svh */
// Assertion macros shared by the chain manager RTL.
`ifndef FAT_BLOCK_CHAIN_MANAGER_MACROS_SVH
`define FAT_BLOCK_CHAIN_MANAGER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define FBCM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chain manager check failed");

// Check a consequent in the cycle after its antecedent.
`define FBCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chain manager check failed");

`endif

/* design/fbcm_pkg.sv */
// Types, constants and helpers of the block chain manager.
package fbcm_pkg;

  localparam int NUM_BLOCKS    = 256;
  localparam int ROOT_ENTRIES  = 16;
  localparam int TABLE_BLOCKS  = 11;
  localparam int FIRST_DATA    = TABLE_BLOCKS + 2;
  localparam int BLK_W         = 8;
  localparam int LINK_W        = 9;
  localparam int DIR_W         = 4;
  localparam int NAME_W        = 48;
  localparam logic [LINK_W-1:0] RESERVED_MARK = 9'd511;

  typedef enum logic [3:0] {
    CMD_FORMAT = 4'd0,
    CMD_CREATE = 4'd1,
    CMD_REMOVE = 4'd2,
    CMD_APPEND = 4'd3,
    CMD_DELETE = 4'd4,
    CMD_CHECK  = 4'd5,
    CMD_NEXT   = 4'd6,
    CMD_FIRST  = 4'd7,
    CMD_LIST   = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_ROOT_FULL = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_SPACE  = 3'd4,
    ST_NOT_IN    = 3'd5,
    ST_NOT_EMPTY = 3'd6
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [BLK_W-1:0]    blk;
    logic                found;
    logic [NAME_W-1:0]   name;
    logic                name_valid;
    logic                last;
  } res_t;

  // Link table write port.
  typedef struct packed {
    logic              we;
    logic [BLK_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
  } link_wr_t;

  // A link points to a real block: nonzero, in range, not reserved.
  function automatic logic link_ok(logic [LINK_W-1:0] v);
    return (v[LINK_W-1] == 1'b0) && (v[BLK_W-1:0] != '0);
  endfunction

  function automatic res_t mk_res(status_e s, logic [BLK_W-1:0] b, logic f);
    res_t r;
    r.status     = s;
    r.blk        = b;
    r.found      = f;
    r.name       = '0;
    r.name_valid = 1'b0;
    r.last       = 1'b1;
    return r;
  endfunction

  // One word of a directory listing.
  function automatic res_t mk_list_res(logic [NAME_W-1:0] nm, logic nv, logic lst);
    res_t r;
    r            = mk_res(ST_OK, '0, 1'b0);
    r.name       = nm;
    r.name_valid = nv;
    r.last       = lst;
    return r;
  endfunction

  // Formatted contents of table entry i for n managed blocks.
  function automatic logic [LINK_W-1:0] fmt_value(logic [LINK_W-1:0] i,
                                                  logic [LINK_W-1:0] n);
    logic [LINK_W-1:0] fd;
    logic [LINK_W:0]   nxt;
    logic [LINK_W-1:0] v;
    fd  = LINK_W'(FIRST_DATA);
    nxt = {1'b0, i} + 1'b1;
    v   = '0;
    if (i == '0) begin
      v = (fd < n) ? fd : '0;
    end else if (i < fd) begin
      v = (i < n) ? RESERVED_MARK : '0;
    end else if (nxt < {1'b0, n}) begin
      v = nxt[LINK_W-1:0];
    end
    return v;
  endfunction

endpackage

/* design/fat_block_chain_manager.sv */
// Top level of the file allocation table block chain manager.
//
// Usage: a command word is taken when start_i is high and busy_o is low.
// Each command gives one result word on valid_o for a single cycle (list
// gives sixteen, one per cycle, the last marked by last_o); the receiver
// cannot stall, so sample every cycle valid_o is high. An undefined opcode
// is answered without leaving idle, so busy_o stays low. Create, remove,
// first and the chain commands scan the directory one entry a cycle up to
// a match, and the chain commands then walk the chain step by step: a link
// table read is registered and the next address depends on that data, so
// each step waits for the read. Format sweeps all 256 table entries, one
// per cycle. After reset the same sweep runs with busy_o high and no
// result; cfg writes are taken at any time and apply at the next format.
`include "fat_block_chain_manager_macros.svh"

module fat_block_chain_manager
  import fbcm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [3:0]        command_i,
  input  logic [NAME_W-1:0] file_name_i,
  input  logic [BLK_W-1:0]  block_number_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LINK_W-1:0] cfg_data_i,
  output logic              valid_o,
  output logic [2:0]        status_o,
  output logic [BLK_W-1:0]  block_result_o,
  output logic              found_o,
  output logic [NAME_W-1:0] listed_name_o,
  output logic              name_valid_o,
  output logic              last_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_FMT, S_SCAN, S_DISP, S_LIST,
    S_AP_HEAD, S_AP_POP, S_AP_LINK, S_AP_CLR, S_AP_RD, S_AP_CHK,
    S_WK_TEST, S_WK_STEP, S_NX, S_DL_L, S_DL_H, S_DL_F
  } state_e;

  state_e            state_q;
  logic [LINK_W-1:0] total_q;
  logic [LINK_W-1:0] n_q;          // managed blocks latched at format start
  logic [LINK_W-1:0] cnt_q;        // format sweep index
  logic              fmt_report_q; // format came from a command, not reset
  logic [3:0]        cmd_q;
  logic [NAME_W-1:0] name_q;
  logic [BLK_W-1:0]  blk_q;
  logic [DIR_W-1:0]  idx_q;
  logic              match_q;
  logic [DIR_W-1:0]  e_q;
  logic              free_found_q;
  logic [DIR_W-1:0]  free_idx_q;
  logic [BLK_W-1:0]  a_q;          // block popped by append
  logic [LINK_W-1:0] b_q;          // walk cursor
  logic [LINK_W-1:0] steps_q;
  logic [LINK_W-1:0] prev_q;       // predecessor of the cursor
  logic              hit_first_q;
  logic [ROOT_ENTRIES-1:0] used_q;
  logic [NAME_W-1:0] dname_q  [ROOT_ENTRIES];
  logic [LINK_W-1:0] dfirst_q [ROOT_ENTRIES];
  logic              valid_q;
  res_t              res_q;

  link_wr_t          wr;
  logic [BLK_W-1:0]  raddr;
  logic [LINK_W-1:0] rdata;

  fbcm_link_ram u_link_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Drive the link table ports from the current step.
  always_comb begin
    wr    = '0;
    raddr = '0;
    case (state_q)
      S_FMT: begin
        wr.we    = 1'b1;
        wr.waddr = cnt_q[BLK_W-1:0];
        wr.wdata = fmt_value(cnt_q, n_q);
      end
      S_AP_HEAD: raddr = '0;
      S_AP_POP:  raddr = rdata[BLK_W-1:0];
      S_AP_LINK: begin
        wr.we    = 1'b1;
        wr.waddr = '0;
        wr.wdata = rdata;
      end
      S_AP_CLR: begin
        wr.we    = 1'b1;
        wr.waddr = a_q;
        wr.wdata = '0;
      end
      S_AP_RD:   raddr = b_q[BLK_W-1:0];
      S_AP_CHK: begin
        if (steps_q[LINK_W-1] || !link_ok(rdata)) begin
          wr.we    = 1'b1;
          wr.waddr = b_q[BLK_W-1:0];
          wr.wdata = {1'b0, a_q};
        end
      end
      S_WK_TEST: raddr = b_q[BLK_W-1:0];
      S_DL_L: begin
        raddr = '0;
        if (!hit_first_q) begin
          wr.we    = 1'b1;
          wr.waddr = prev_q[BLK_W-1:0];
          wr.wdata = rdata;
        end
      end
      S_DL_H: begin
        wr.we    = 1'b1;
        wr.waddr = blk_q;
        wr.wdata = rdata;
      end
      S_DL_F: begin
        wr.we    = 1'b1;
        wr.waddr = '0;
        wr.wdata = {1'b0, blk_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_FMT;
      total_q      <= LINK_W'(NUM_BLOCKS);
      n_q          <= LINK_W'(NUM_BLOCKS);
      cnt_q        <= '0;
      fmt_report_q <= 1'b0;
      cmd_q        <= '0;
      name_q       <= '0;
      blk_q        <= '0;
      idx_q        <= '0;
      match_q      <= 1'b0;
      e_q          <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      a_q          <= '0;
      b_q          <= '0;
      steps_q      <= '0;
      prev_q       <= '0;
      hit_first_q  <= 1'b0;
      used_q       <= '0;
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
        dname_q[i]  <= '0;
        dfirst_q[i] <= '0;
      end
      valid_q      <= 1'b0;
      res_q        <= '0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q        <= command_i;
            name_q       <= file_name_i;
            blk_q        <= block_number_i;
            idx_q        <= '0;
            match_q      <= 1'b0;
            free_found_q <= 1'b0;
            if (command_i == CMD_FORMAT) begin
              // Clip to the table size and sweep the whole table.
              n_q          <= (total_q > LINK_W'(NUM_BLOCKS)) ? LINK_W'(NUM_BLOCKS)
                                                              : total_q;
              cnt_q        <= '0;
              fmt_report_q <= 1'b1;
              state_q      <= S_FMT;
            end else if (command_i == CMD_LIST) begin
              state_q <= S_LIST;
            end else if (command_i > CMD_LIST) begin
              valid_q <= 1'b1;
              res_q   <= mk_res(ST_OK, '0, 1'b0);
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_FMT: begin
          used_q <= '0;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q[BLK_W-1:0] == BLK_W'(NUM_BLOCKS - 1)) begin
            if (fmt_report_q) begin
              valid_q <= 1'b1;
              res_q   <= mk_res(ST_OK, '0, 1'b0);
            end
            state_q <= S_IDLE;
          end
        end
        S_LIST: begin
          valid_q <= 1'b1;
          res_q   <= mk_list_res(used_q[idx_q] ? dname_q[idx_q] : '0, used_q[idx_q],
                                 idx_q == DIR_W'(ROOT_ENTRIES - 1));
          idx_q   <= idx_q + 1'b1;
          if (idx_q == DIR_W'(ROOT_ENTRIES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          // Look at one directory entry a cycle; note the lowest free one.
          if (used_q[idx_q] && dname_q[idx_q] == name_q) begin
            match_q <= 1'b1;
            e_q     <= idx_q;
            state_q <= S_DISP;
          end else begin
            if (!used_q[idx_q] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= idx_q;
            end
            idx_q <= idx_q + 1'b1;
            if (idx_q == DIR_W'(ROOT_ENTRIES - 1)) begin
              state_q <= S_DISP;
            end
          end
        end
        S_DISP: begin
          state_q <= S_IDLE;
          if (cmd_q == CMD_CREATE) begin
            valid_q <= 1'b1;
            if (match_q) begin
              res_q <= mk_res(ST_EXISTS, '0, 1'b0);
            end else if (free_found_q) begin
              used_q[free_idx_q]   <= 1'b1;
              dname_q[free_idx_q]  <= name_q;
              dfirst_q[free_idx_q] <= '0;
              res_q <= mk_res(ST_OK, '0, 1'b0);
            end else begin
              res_q <= mk_res(ST_ROOT_FULL, '0, 1'b0);
            end
          end else if (!match_q) begin
            valid_q <= 1'b1;
            res_q   <= mk_res(ST_NOT_FOUND, '0, 1'b0);
          end else begin
            case (cmd_q)
              CMD_REMOVE: begin
                valid_q <= 1'b1;
                if (dfirst_q[e_q] != '0) begin
                  res_q <= mk_res(ST_NOT_EMPTY, '0, 1'b0);
                end else begin
                  used_q[e_q] <= 1'b0;
                  res_q       <= mk_res(ST_OK, '0, 1'b0);
                end
              end
              CMD_FIRST: begin
                valid_q <= 1'b1;
                res_q   <= mk_res(ST_OK, dfirst_q[e_q][BLK_W-1:0], 1'b0);
              end
              CMD_APPEND: state_q <= S_AP_HEAD;
              default: begin
                // Delete, check and next walk the chain from its head.
                b_q         <= dfirst_q[e_q];
                steps_q     <= '0;
                hit_first_q <= 1'b0;
                state_q     <= S_WK_TEST;
              end
            endcase
          end
        end
        S_AP_HEAD: state_q <= S_AP_POP;
        S_AP_POP: begin
          if (!link_ok(rdata)) begin
            valid_q <= 1'b1;
            res_q   <= mk_res(ST_NO_SPACE, '0, 1'b0);
            state_q <= S_IDLE;
          end else begin
            a_q     <= rdata[BLK_W-1:0];
            state_q <= S_AP_LINK;
          end
        end
        S_AP_LINK: state_q <= S_AP_CLR;
        S_AP_CLR: begin
          if (!link_ok(dfirst_q[e_q])) begin
            dfirst_q[e_q] <= {1'b0, a_q};
            valid_q       <= 1'b1;
            res_q         <= mk_res(ST_OK, a_q, 1'b0);
            state_q       <= S_IDLE;
          end else begin
            b_q     <= dfirst_q[e_q];
            steps_q <= '0;
            state_q <= S_AP_RD;
          end
        end
        S_AP_RD: state_q <= S_AP_CHK;
        S_AP_CHK: begin
          // Advance to the tail; the port logic links the new block there.
          if (!steps_q[LINK_W-1] && link_ok(rdata)) begin
            b_q     <= rdata;
            steps_q <= steps_q + 1'b1;
            state_q <= S_AP_RD;
          end else begin
            valid_q <= 1'b1;
            res_q   <= mk_res(ST_OK, a_q, 1'b0);
            state_q <= S_IDLE;
          end
        end
        S_WK_TEST: begin
          if (steps_q[LINK_W-1] || !link_ok(b_q)) begin
            valid_q <= 1'b1;
            res_q   <= (cmd_q == CMD_CHECK) ? mk_res(ST_OK, '0, 1'b0)
                                            : mk_res(ST_NOT_IN, '0, 1'b0);
            state_q <= S_IDLE;
          end else if (b_q[BLK_W-1:0] == blk_q) begin
            // The read just issued fetches the link of the block itself.
            hit_first_q <= (steps_q == '0);
            if (cmd_q == CMD_CHECK) begin
              valid_q <= 1'b1;
              res_q   <= mk_res(ST_OK, '0, 1'b1);
              state_q <= S_IDLE;
            end else if (cmd_q == CMD_NEXT) begin
              state_q <= S_NX;
            end else begin
              state_q <= S_DL_L;
            end
          end else begin
            prev_q  <= b_q;
            state_q <= S_WK_STEP;
          end
        end
        S_WK_STEP: begin
          b_q     <= rdata;
          steps_q <= steps_q + 1'b1;
          state_q <= S_WK_TEST;
        end
        S_NX: begin
          valid_q <= 1'b1;
          res_q   <= mk_res(ST_OK, link_ok(rdata) ? rdata[BLK_W-1:0] : '0, 1'b0);
          state_q <= S_IDLE;
        end
        S_DL_L: begin
          if (hit_first_q) begin
            dfirst_q[e_q] <= rdata;
          end
          state_q <= S_DL_H;
        end
        S_DL_H: state_q <= S_DL_F;
        S_DL_F: begin
          valid_q <= 1'b1;
          res_q   <= mk_res(ST_OK, '0, 1'b0);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign valid_o        = valid_q;
  assign status_o       = res_q.status;
  assign block_result_o = res_q.blk;
  assign found_o        = res_q.found;
  assign listed_name_o  = res_q.name;
  assign name_valid_o   = res_q.name_valid;
  assign last_o         = res_q.last;

  // Hold list words back to back until the last one.
  `FBCM_ASSERT_NEXT(a_list_burst, valid_o && !last_o, valid_o)
  // Take a defined command word only to start work.
  `FBCM_ASSERT_NEXT(a_accept_busy, start_i && !busy_o && command_i <= CMD_LIST, busy_o)
  // A listed name word carries no status and no block.
  `FBCM_ASSERT_SAME(a_named_clean, valid_o && name_valid_o,
                    status_o == ST_OK && block_result_o == '0)
  `FBCM_ASSERT_SAME(a_status_range, valid_o, status_o <= ST_NOT_EMPTY)

endmodule

/* design/fbcm_link_ram.sv */
// Link table memory: one write port, one registered read port.
module fbcm_link_ram
  import fbcm_pkg::*;
(
  input  logic              clk_i,
  input  link_wr_t          wr_i,
  input  logic [BLK_W-1:0]  raddr_i,
  output logic [LINK_W-1:0] rdata_o
);

  logic [LINK_W-1:0] mem_q [NUM_BLOCKS];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.waddr] <= wr_i.wdata;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* test/tb_fat_block_chain_manager.sv */
// Testbench for the allocation table block chain manager.
module tb_fat_block_chain_manager;
  import fbcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes past list are undefined and must come back as a bare last word.
  localparam logic [3:0] CMD_UNDEF_LO = 4'd9;
  localparam logic [3:0] CMD_UNDEF_HI = 4'd15;
  localparam int MAX_GAP = 17;

  typedef struct {
    logic [2:0]        status;
    logic [BLK_W-1:0]  blk;
    logic              found;
    logic [NAME_W-1:0] name;
    logic              name_valid;
    logic              last;
  } word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [3:0]        command_i = '0;
  logic [NAME_W-1:0] file_name_i = '0;
  logic [BLK_W-1:0]  block_number_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LINK_W-1:0] cfg_data_i = '0;
  logic              valid_o;
  logic [2:0]        status_o;
  logic [BLK_W-1:0]  block_result_o;
  logic              found_o;
  logic [NAME_W-1:0] listed_name_o;
  logic              name_valid_o;
  logic              last_o;

  fat_block_chain_manager u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .file_name_i, .block_number_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .valid_o, .status_o, .block_result_o,
    .found_o, .listed_name_o, .name_valid_o, .last_o
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the table, the directory and the block count register.
  logic [LINK_W-1:0] shadow_fat [NUM_BLOCKS];
  logic              shadow_used [ROOT_ENTRIES];
  logic [NAME_W-1:0] shadow_name [ROOT_ENTRIES];
  logic [BLK_W-1:0]  shadow_first [ROOT_ENTRIES];
  logic [LINK_W-1:0] shadow_total;

  word_t             expected_words [$];
  int                mismatches = 0;
  logic [NAME_W-1:0] name_pool [6];

  function automatic logic link_valid(logic [LINK_W-1:0] v);
    return v != '0 && v < NUM_BLOCKS && v != RESERVED_MARK;
  endfunction

  function automatic int lookup_file(logic [NAME_W-1:0] nm);
    for (int i = 0; i < ROOT_ENTRIES; i++)
      if (shadow_used[i] && shadow_name[i] == nm) return i;
    return -1;
  endfunction

  function automatic logic in_chain(int e, logic [BLK_W-1:0] b);
    logic [LINK_W-1:0] p;
    p = {1'b0, shadow_first[e]};
    for (int s = 0; s < NUM_BLOCKS && link_valid(p); s++) begin
      if (p == {1'b0, b}) return 1'b1;
      p = shadow_fat[p];
    end
    return 1'b0;
  endfunction

  function automatic void rebuild_table();
    int n;
    n = (shadow_total > NUM_BLOCKS) ? NUM_BLOCKS : int'(shadow_total);
    foreach (shadow_fat[i]) shadow_fat[i] = '0;
    for (int i = 1; i < FIRST_DATA && i < n; i++) shadow_fat[i] = RESERVED_MARK;
    if (FIRST_DATA < n) begin
      shadow_fat[0] = LINK_W'(FIRST_DATA);
      for (int i = FIRST_DATA; i + 1 < n; i++) shadow_fat[i] = LINK_W'(i + 1);
      shadow_fat[n-1] = '0;
    end
    for (int i = 0; i < ROOT_ENTRIES; i++) begin
      shadow_used[i] = 1'b0;
      shadow_name[i] = '0;
      shadow_first[i] = '0;
    end
  endfunction

  // Append one expected word at the tail of the queue.
  function automatic void queue_word(word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void push_word(logic [2:0] st, logic [BLK_W-1:0] b, logic f);
    word_t w;
    w.status = st; w.blk = b; w.found = f;
    w.name = '0; w.name_valid = 1'b0; w.last = 1'b1;
    queue_word(w);
  endfunction

  // Advance the shadow state by one command and queue the words it gives.
  function automatic void apply_command(logic [3:0] cmd, logic [NAME_W-1:0] nm,
                                        logic [BLK_W-1:0] b);
    int e;
    word_t w;
    logic [LINK_W-1:0] a, p;
    if (cmd == CMD_LIST) begin
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
        w.status = ST_OK; w.blk = '0; w.found = 1'b0;
        w.name = shadow_used[i] ? shadow_name[i] : '0;
        w.name_valid = shadow_used[i];
        w.last = (i == ROOT_ENTRIES - 1);
        queue_word(w);
      end
      return;
    end
    if (cmd == CMD_FORMAT) begin
      rebuild_table();
      push_word(ST_OK, '0, 1'b0);
      return;
    end
    if (cmd == CMD_CREATE) begin
      if (lookup_file(nm) >= 0) begin
        push_word(ST_EXISTS, '0, 1'b0);
        return;
      end
      for (int i = 0; i < ROOT_ENTRIES; i++)
        if (!shadow_used[i]) begin
          shadow_used[i] = 1'b1;
          shadow_name[i] = nm;
          shadow_first[i] = '0;
          push_word(ST_OK, '0, 1'b0);
          return;
        end
      push_word(ST_ROOT_FULL, '0, 1'b0);
      return;
    end
    if (cmd > CMD_LIST) begin
      push_word(ST_OK, '0, 1'b0);
      return;
    end
    e = lookup_file(nm);
    if (e < 0) begin
      push_word(ST_NOT_FOUND, '0, 1'b0);
      return;
    end
    case (cmd)
      CMD_REMOVE: begin
        if (shadow_first[e] != '0) push_word(ST_NOT_EMPTY, '0, 1'b0);
        else begin
          shadow_used[e] = 1'b0;
          push_word(ST_OK, '0, 1'b0);
        end
      end
      CMD_APPEND: begin
        a = shadow_fat[0];
        if (!link_valid(a)) push_word(ST_NO_SPACE, '0, 1'b0);
        else begin
          shadow_fat[0] = shadow_fat[a];
          shadow_fat[a] = '0;
          if (!link_valid({1'b0, shadow_first[e]})) shadow_first[e] = a[BLK_W-1:0];
          else begin
            p = {1'b0, shadow_first[e]};
            for (int s = 0; s < NUM_BLOCKS && link_valid(shadow_fat[p]); s++)
              p = shadow_fat[p];
            shadow_fat[p] = a;
          end
          push_word(ST_OK, a[BLK_W-1:0], 1'b0);
        end
      end
      CMD_DELETE: begin
        if (!in_chain(e, b)) push_word(ST_NOT_IN, '0, 1'b0);
        else begin
          if (shadow_first[e] == b) shadow_first[e] = shadow_fat[b][BLK_W-1:0];
          else begin
            p = {1'b0, shadow_first[e]};
            for (int s = 0; s < NUM_BLOCKS && link_valid(p); s++) begin
              if (shadow_fat[p] == {1'b0, b}) begin
                shadow_fat[p] = shadow_fat[b];
                break;
              end
              p = shadow_fat[p];
            end
          end
          shadow_fat[b] = shadow_fat[0];
          shadow_fat[0] = {1'b0, b};
          push_word(ST_OK, '0, 1'b0);
        end
      end
      CMD_CHECK: push_word(ST_OK, '0, in_chain(e, b));
      CMD_NEXT: begin
        if (!in_chain(e, b)) push_word(ST_NOT_IN, '0, 1'b0);
        else push_word(ST_OK, link_valid(shadow_fat[b]) ? shadow_fat[b][BLK_W-1:0] : '0,
                       1'b0);
      end
      default: push_word(ST_OK, shadow_first[e], 1'b0);
    endcase
  endfunction

  // Compare every result word against the oldest expectation.
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && valid_o) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, status %0d", status_o);
      end else begin
        w = expected_words.pop_front();
        if (status_o !== w.status || block_result_o !== w.blk || found_o !== w.found ||
            listed_name_o !== w.name || name_valid_o !== w.name_valid ||
            last_o !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d blk=%0d fnd=%b nm=%h nv=%b last=%b",
                      " / got st=%0d blk=%0d fnd=%b nm=%h nv=%b last=%b"},
                     w.status, w.blk, w.found, w.name, w.name_valid, w.last,
                     status_o, block_result_o, found_o, listed_name_o, name_valid_o,
                     last_o);
        end
      end
    end
  end

  // Send one command word after a random gap; start stays high for back-to-back words.
  task automatic send_command(logic [3:0] cmd, logic [NAME_W-1:0] nm, logic [BLK_W-1:0] b);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    file_name_i <= nm;
    block_number_i <= b;
    do @(posedge clk_i); while (busy_o);
    apply_command(cmd, nm, b);
  endtask

  // Hold off the sender until every expected word has arrived.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_block_count(logic [LINK_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_total = v;
  endtask

  task automatic test_file_basics();
    logic [NAME_W-1:0] ones, zero;
    ones = '1;
    zero = '0;
    send_command(CMD_FIRST, ones, '0);
    send_command(CMD_CREATE, ones, '0);
    send_command(CMD_CREATE, ones, '0);
    send_command(CMD_CREATE, zero, '0);
    send_command(CMD_FIRST, ones, '0);
    send_command(CMD_APPEND, ones, '0);
    send_command(CMD_APPEND, ones, '0);
    send_command(CMD_APPEND, zero, '0);
    send_command(CMD_APPEND, ones, '0);
    send_command(CMD_CHECK, ones, 8'd14);
    send_command(CMD_CHECK, ones, 8'd15);
    send_command(CMD_CHECK, ones, 8'd255);
    send_command(CMD_NEXT, ones, 8'd13);
    send_command(CMD_NEXT, ones, 8'd16);
    send_command(CMD_NEXT, ones, 8'd1);
    send_command(CMD_DELETE, ones, 8'd14);
    send_command(CMD_DELETE, ones, 8'd14);
    send_command(CMD_REMOVE, ones, '0);
    send_command(CMD_DELETE, zero, 8'd15);
    send_command(CMD_REMOVE, zero, '0);
    send_command(CMD_NEXT, 48'h123456789abc, 8'd13);
    send_command(CMD_LIST, '0, '0);
    send_command(CMD_UNDEF_HI, ones, 8'hff);
    send_command(CMD_UNDEF_LO, '0, '0);
  endtask

  task automatic test_root_full();
    send_command(CMD_FORMAT, '0, '0);
    for (int i = 0; i <= ROOT_ENTRIES; i++)
      send_command(CMD_CREATE, NAME_W'({$urandom, $urandom}), '0);
    send_command(CMD_LIST, '0, '0);
  endtask

  task automatic test_no_space();
    write_block_count(9'd14);
    send_command(CMD_FORMAT, '0, '0);
    send_command(CMD_CREATE, name_pool[0], '0);
    send_command(CMD_APPEND, name_pool[0], '0);
    send_command(CMD_APPEND, name_pool[0], '0);
    send_command(CMD_DELETE, name_pool[0], 8'd13);
    send_command(CMD_APPEND, name_pool[0], '0);
  endtask

  // Mostly well-formed traffic on a few files, with occasional noise.
  task automatic test_random_traffic(int count);
    int e, k, pick, len;
    logic [3:0] cmd;
    logic [NAME_W-1:0] nm;
    logic [BLK_W-1:0] b;
    logic [LINK_W-1:0] p;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_APPEND;
      else if (pick < 42) cmd = CMD_CREATE;
      else if (pick < 56) cmd = CMD_DELETE;
      else if (pick < 66) cmd = CMD_CHECK;
      else if (pick < 76) cmd = CMD_NEXT;
      else if (pick < 82) cmd = CMD_FIRST;
      else if (pick < 90) cmd = CMD_REMOVE;
      else if (pick < 94) cmd = CMD_LIST;
      else if (pick < 96) cmd = CMD_FORMAT;
      else cmd = 4'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
      nm = ($urandom_range(0, 9) == 0) ? NAME_W'({$urandom, $urandom})
                                       : name_pool[$urandom_range(0, 5)];
      b = 8'($urandom);
      e = lookup_file(nm);
      // Aim block operands at real chain members most of the time.
      if (e >= 0 && shadow_first[e] != '0 && $urandom_range(0, 9) < 7) begin
        len = 0;
        p = {1'b0, shadow_first[e]};
        while (link_valid(p) && len < NUM_BLOCKS) begin
          len++;
          p = shadow_fat[p];
        end
        k = $urandom_range(0, len - 1);
        p = {1'b0, shadow_first[e]};
        repeat (k) p = shadow_fat[p];
        b = p[BLK_W-1:0];
      end
      send_command(cmd, nm, b);
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) name_pool[i] = NAME_W'({$urandom, $urandom});
    shadow_total = 9'd256;
    rebuild_table();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_file_basics();
    test_root_full();
    test_no_space();
    write_block_count(9'd256);
    send_command(CMD_FORMAT, '0, '0);
    test_random_traffic(25);
    write_block_count(9'($urandom_range(15, 40)));
    send_command(CMD_FORMAT, '0, '0);
    test_random_traffic(25);
    drain();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("** fat_block_chain_manager: PASSED **");
    else $display("** fat_block_chain_manager: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** fat_block_chain_manager: FAILED **");
    $finish;
  end

endmodule
